// ===== src/lphm_pkg.sv =====
// Shared types and codes for the linear probing hash map.
package lphm_pkg;

    // Operation kinds
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ABSENT   = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;

    // Mixer multiplier
    localparam logic [31:0] MIX_MUL = 32'h045d_9f3b;

    // One request as accepted on the input stream
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [31:0] value;
    } req_t;

    // One slot as stored in the table memory
    typedef struct packed {
        logic        used;
        logic        deleted;
        logic [31:0] value;
        logic [31:0] key;
    } entry_t;

endpackage

// ===== src/lphm_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module lphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lphm_front.sv =====
// Front end: accepts requests and computes the home slot of each key.
module lphm_front #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  lphm_pkg::req_t                 in_req,
    output logic                           q_valid,
    input  logic                           q_ready,
    output logic [$bits(lphm_pkg::req_t)+$clog2(TABLE_SIZE)-1:0] q_data
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int R_W   = IDX_W + 1;
    localparam bit POW2  = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
    localparam logic [R_W-1:0] TS = R_W'(TABLE_SIZE);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MIX1 = 5'b00010,
        F_MIX2 = 5'b00100,
        F_MOD  = 5'b01000,
        F_PUSH = 5'b10000
    } fstate_t;

    fstate_t        state_reg, state_next;
    lphm_pkg::req_t req_reg, req_next;
    logic [31:0]    x_reg, x_next;
    logic [R_W-1:0] rem_reg, rem_next;
    logic [2:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0] home_reg, home_next;

    logic [31:0]    mixed;
    logic [R_W-1:0] rem_step;

    // Xor with arithmetic shift, then multiply
    assign mixed = ({{16{x_reg[31]}}, x_reg[31:16]} ^ x_reg) * lphm_pkg::MIX_MUL;

    // Four restoring remainder steps on the top nibble
    always_comb
    begin
        rem_step = rem_reg;
        for (int b = 0; b < 4; b++)
        begin
            rem_step = {rem_step[IDX_W-1:0], x_reg[31-b]};
            if (rem_step >= TS)
            begin
                rem_step = rem_step - TS;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        x_next     = x_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        home_next  = home_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_req;
                    x_next     = in_req.key;
                    state_next = F_MIX1;
                end
            end
            F_MIX1:
            begin
                x_next     = mixed;
                state_next = F_MIX2;
            end
            F_MIX2:
            begin
                // Second mix round and the final xor-shift
                x_next = {{16{mixed[31]}}, mixed[31:16]} ^ mixed;
                if (POW2)
                begin
                    home_next  = x_next[IDX_W-1:0];
                    state_next = F_PUSH;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = F_MOD;
                end
            end
            F_MOD:
            begin
                // Eight nibble steps of the remainder
                rem_next = rem_step;
                x_next   = {x_reg[27:0], 4'd0};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    home_next  = rem_step[IDX_W-1:0];
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (q_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        home_reg <= home_next;
    end

    assign in_ready = state_reg == F_IDLE;
    assign q_valid  = state_reg == F_PUSH;
    assign q_data   = {req_reg, home_reg};

endmodule

// ===== src/lphm_queue.sv =====
// Two-entry queue between the front end and the table engine.
module lphm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wptr_reg, rptr_reg;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = data_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wptr_reg] <= in_data;
        end
    end

endmodule

// ===== src/lphm_back.sv =====
// Table engine: probes slots, applies the operation and drives the result register.
module lphm_back #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  logic [$bits(lphm_pkg::req_t)+$clog2(TABLE_SIZE)-1:0] q_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_found,
    output logic [31:0] out_read_value,
    output logic [1:0]  out_status,
    output logic [10:0] out_live_entries
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam int EW    = $bits(lphm_pkg::entry_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_SIZE - 1);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_PROBE = 5'b00010,
        B_CHECK = 5'b00100,
        B_SWEEP = 5'b01000,
        B_DONE  = 5'b10000
    } bstate_t;

    bstate_t          state_reg, state_next;
    lphm_pkg::req_t   req_reg, req_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             tomb_reg, tomb_next;
    logic [IDX_W-1:0] tomb_idx_reg, tomb_idx_next;
    logic [CNT_W-1:0] live_reg, live_next;
    logic             sweep_out_reg, sweep_out_next;
    logic             res_found_reg, res_found_next;
    logic [31:0]      res_value_reg, res_value_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [31:0]      out_value_reg;
    logic [1:0]       out_status_reg;
    logic [10:0]      out_live_reg;

    logic             we;
    logic [IDX_W-1:0] waddr;
    lphm_pkg::entry_t wentry;
    logic [EW-1:0]    rdata;
    lphm_pkg::entry_t rentry;
    logic             load_out;
    logic             tomb_now;
    logic [IDX_W-1:0] tomb_at;

    lphm_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign rentry   = lphm_pkg::entry_t'(rdata);
    assign q_ready  = state_reg == B_IDLE;
    assign load_out = state_reg == B_DONE && (!out_valid_reg || out_ready);

    // Free slot seen so far, including the one under test
    assign tomb_now = tomb_reg || (rentry.used && rentry.deleted);
    assign tomb_at  = tomb_reg ? tomb_idx_reg : idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        tomb_next       = tomb_reg;
        tomb_idx_next   = tomb_idx_reg;
        live_next       = live_reg;
        sweep_out_next  = sweep_out_reg;
        res_found_next  = res_found_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        we              = 1'b0;
        waddr           = idx_reg;
        wentry          = '0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    req_next        = lphm_pkg::req_t'(q_data[$bits(q_data)-1:IDX_W]);
                    idx_next        = q_data[IDX_W-1:0];
                    n_next          = '0;
                    tomb_next       = 1'b0;
                    res_found_next  = 1'b0;
                    res_value_next  = '0;
                    res_status_next = lphm_pkg::STAT_OK;
                    if (req_next.kind == lphm_pkg::KIND_CLEAR)
                    begin
                        idx_next       = '0;
                        sweep_out_next = 1'b1;
                        state_next     = B_SWEEP;
                    end
                    else
                    begin
                        state_next = B_PROBE;
                    end
                end
            end
            B_PROBE:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                priority if (rentry.used && !rentry.deleted && rentry.key == req_reg.key)
                begin
                    // Hit on a live entry
                    res_found_next = 1'b1;
                    state_next     = B_DONE;
                    unique case (req_reg.kind)
                        lphm_pkg::KIND_READ:
                        begin
                            res_value_next = rentry.value;
                        end
                        lphm_pkg::KIND_WRITE:
                        begin
                            we     = 1'b1;
                            wentry = '{used: 1'b1, deleted: 1'b0,
                                       value: req_reg.value, key: req_reg.key};
                        end
                        default:
                        begin
                            we        = 1'b1;
                            wentry    = '{used: 1'b1, deleted: 1'b1,
                                          value: rentry.value, key: rentry.key};
                            live_next = live_reg - CNT_W'(1);
                        end
                    endcase
                end
                else if (!rentry.used || n_reg == LAST_CNT)
                begin
                    // Miss: probe run ended
                    state_next = B_DONE;
                    unique case (req_reg.kind)
                        lphm_pkg::KIND_READ:
                        begin
                            res_value_next = '0;
                        end
                        lphm_pkg::KIND_WRITE:
                        begin
                            if (tomb_now || !rentry.used)
                            begin
                                we        = 1'b1;
                                waddr     = tomb_now ? tomb_at : idx_reg;
                                wentry    = '{used: 1'b1, deleted: 1'b0,
                                              value: req_reg.value, key: req_reg.key};
                                live_next = live_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_status_next = lphm_pkg::STAT_FULL;
                            end
                        end
                        default:
                        begin
                            res_status_next = lphm_pkg::STAT_ABSENT;
                        end
                    endcase
                end
                else
                begin
                    // Step to the next slot, remember the first tombstone
                    if (!tomb_reg && rentry.deleted)
                    begin
                        tomb_next     = 1'b1;
                        tomb_idx_next = idx_reg;
                    end
                    idx_next   = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
                    n_next     = n_reg + CNT_W'(1);
                    state_next = B_PROBE;
                end
            end
            B_SWEEP:
            begin
                // Empty one slot per cycle
                we       = 1'b1;
                waddr    = idx_reg;
                wentry   = '0;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX)
                begin
                    live_next  = '0;
                    state_next = sweep_out_reg ? B_DONE : B_IDLE;
                end
            end
            B_DONE:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_SWEEP;
            idx_reg       <= '0;
            n_reg         <= '0;
            tomb_reg      <= 1'b0;
            live_reg      <= '0;
            sweep_out_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            tomb_reg      <= tomb_next;
            live_reg      <= live_next;
            sweep_out_reg <= sweep_out_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold payload of the pending and the presented result
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        tomb_idx_reg   <= tomb_idx_next;
        res_found_reg  <= res_found_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (load_out)
        begin
            out_found_reg  <= res_found_reg;
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
            out_live_reg   <= 11'(live_reg);
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_found        = out_found_reg;
    assign out_read_value   = out_value_reg;
    assign out_status       = out_status_reg;
    assign out_live_entries = out_live_reg;

endmodule

// ===== src/linear_probe_hash_map_top.sv =====
// Top level of the linear probing hash map.
// Key to value table with open addressing, linear probing and tombstones, one
// result beat per request beat. The front end hashes a key in two mix rounds
// and takes the home slot from its low bits if TABLE_SIZE is a power of two,
// else from a remainder unit that takes four bits a cycle; a two-entry queue
// lets it hash the next key while the table engine works. The engine probes
// each slot in B_PROBE, then B_CHECK (one read port of the table memory with
// registered data); it takes the request from the queue in B_IDLE and loads
// the result register in B_DONE, and a hit or miss probes at most TABLE_SIZE
// slots. A clear walks the whole table, and the same pass runs after reset
// before the first request is processed (requests are still taken into the
// queue meanwhile).
module linear_probe_hash_map_top #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[31:0], write_value[63:32]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // found[0], read_value[32:1], live_entries[43:33], zero
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int QW    = $bits(lphm_pkg::req_t) + IDX_W;

    lphm_pkg::req_t in_req;
    logic           fq_valid, fq_ready;
    logic [QW-1:0]  fq_data;
    logic           qb_valid, qb_ready;
    logic [QW-1:0]  qb_data;
    logic           found;
    logic [31:0]    read_value;
    logic [10:0]    live_entries;

    assign in_req = '{kind: s_tuser, key: s_tdata[31:0], value: s_tdata[63:32]};

    lphm_front #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (in_req),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    lphm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    lphm_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (qb_valid),
        .q_ready          (qb_ready),
        .q_data           (qb_data),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_found        (found),
        .out_read_value   (read_value),
        .out_status       (m_tuser),
        .out_live_entries (live_entries)
    );

    assign m_tdata = {4'd0, live_entries, read_value, found};

endmodule

// ===== src/lphm_checker.sv =====
// Port-level checks for the hash map top level, and their binding.
module lphm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Status only takes defined codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= lphm_pkg::STAT_FULL)
        else $error("undefined status code");

    // A failed operation never reports a hit or a nonzero read value
    a_fail_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != lphm_pkg::STAT_OK |-> !m_tdata[0] && m_tdata[32:1] == 32'd0)
        else $error("failed operation shows a hit");

    // A nonzero read value comes only with a hit
    a_value_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32:1] != 32'd0 |-> m_tdata[0])
        else $error("read value without a hit");

endmodule

bind linear_probe_hash_map_top lphm_checker u_lphm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
